// ===== rtl/core/hslc_pkg.sv =====
// shared types and constants for the hsv signal light classifier
package hslc_pkg;

  localparam int unsigned CountBits = 22;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [8:0] RedHueLo = 9'd22;
  localparam logic [8:0] RedHueHi = 9'd330;
  localparam logic [8:0] GreenHueLo = 9'd125;
  localparam logic [8:0] GreenHueHi = 9'd206;
  localparam logic [8:0] AmberHueLo = 9'd30;
  localparam logic [8:0] AmberHueHi = 9'd75;

  localparam logic [7:0] RedSatRst = 8'd170;
  localparam logic [7:0] GreenSatRst = 8'd100;
  localparam logic [7:0] AmberSatRst = 8'd127;
  localparam logic [7:0] ValueRst = 8'd50;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_RED_SAT   = 2'd0,
    REG_GREEN_SAT = 2'd1,
    REG_AMBER_SAT = 2'd2,
    REG_VALUE_MIN = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_RED   = 2'd1,
    CLS_GREEN = 2'd2,
    CLS_AMBER = 2'd3
  } pixel_class_e;

  typedef logic [CountBits-1:0] count_t;

  typedef struct packed {
    logic [7:0] red_sat_min;
    logic [7:0] green_sat_min;
    logic [7:0] amber_sat_min;
    logic [7:0] value_min;
  } thresh_t;

  typedef struct packed {
    logic         step;
    logic         last;
    pixel_class_e cls;
  } tally_ctrl_t;

endpackage

// ===== rtl/core/hslc_classify.sv =====
// per-pixel hue, saturation and brightness threshold tests
module hslc_classify (
  input  hslc_pkg::thresh_t      thresh_i,
  input  logic [7:0]             hue_half_deg_i,
  input  logic [7:0]             saturation_i,
  input  logic [7:0]             brightness_i,
  output hslc_pkg::pixel_class_e pixel_class_o
);
  import hslc_pkg::*;

  logic [8:0] hue_deg;
  logic       bright_ok;
  logic       red_hit;
  logic       green_hit;
  logic       amber_hit;

  assign hue_deg = {hue_half_deg_i, 1'b0};
  assign bright_ok = brightness_i >= thresh_i.value_min;
  assign red_hit = ((hue_deg <= RedHueLo) || (hue_deg >= RedHueHi)) &&
                   (saturation_i >= thresh_i.red_sat_min);
  assign green_hit = (hue_deg >= GreenHueLo) && (hue_deg <= GreenHueHi) &&
                     (saturation_i >= thresh_i.green_sat_min);
  assign amber_hit = (hue_deg >= AmberHueLo) && (hue_deg <= AmberHueHi) &&
                     (saturation_i >= thresh_i.amber_sat_min);

  always_comb begin
    if (!bright_ok) begin
      pixel_class_o = CLS_NONE;
    end else if (red_hit) begin
      pixel_class_o = CLS_RED;
    end else if (green_hit) begin
      pixel_class_o = CLS_GREEN;
    end else if (amber_hit) begin
      pixel_class_o = CLS_AMBER;
    end else begin
      pixel_class_o = CLS_NONE;
    end
  end

endmodule

// ===== rtl/core/hslc_tally.sv =====
// per-frame color counters with saturation and frame winner selection
module hslc_tally (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hslc_pkg::tally_ctrl_t  ctrl_i,
  output hslc_pkg::count_t       red_total_o,
  output hslc_pkg::count_t       green_total_o,
  output hslc_pkg::count_t       amber_total_o,
  output hslc_pkg::pixel_class_e frame_color_o
);
  import hslc_pkg::*;

  localparam count_t CountMax = {CountBits{1'b1}};

  count_t red_q, red_d;
  count_t green_q, green_d;
  count_t amber_q, amber_d;

  function automatic count_t bump(input count_t c);
    bump = (c == CountMax) ? c : c + count_t'(1);
  endfunction

  always_comb begin
    red_total_o = red_q;
    green_total_o = green_q;
    amber_total_o = amber_q;
    case (ctrl_i.cls)
      CLS_RED:   red_total_o = bump(red_q);
      CLS_GREEN: green_total_o = bump(green_q);
      CLS_AMBER: amber_total_o = bump(amber_q);
      default:   ;
    endcase
  end

  always_comb begin
    frame_color_o = CLS_NONE;
    if (ctrl_i.last && ((red_total_o | green_total_o | amber_total_o) != '0)) begin
      if ((red_total_o >= green_total_o) && (red_total_o >= amber_total_o)) begin
        frame_color_o = CLS_RED;
      end else if (green_total_o >= amber_total_o) begin
        frame_color_o = CLS_GREEN;
      end else begin
        frame_color_o = CLS_AMBER;
      end
    end
  end

  always_comb begin
    red_d = red_q;
    green_d = green_q;
    amber_d = amber_q;
    if (ctrl_i.step) begin
      if (ctrl_i.last) begin
        red_d = '0;
        green_d = '0;
        amber_d = '0;
      end else begin
        red_d = red_total_o;
        green_d = green_total_o;
        amber_d = amber_total_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= '0;
      green_q <= '0;
      amber_q <= '0;
    end else begin
      red_q <= red_d;
      green_q <= green_d;
      amber_q <= amber_d;
    end
  end

endmodule

// ===== rtl/core/hsv_signal_light_classifier_core.sv =====
// top level of the hsv signal light classifier: config, pixel and result registers
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | hue_half_deg, saturation, brightness,
//          |           |                           | frame_last
//  out     | output    | out_valid_o / out_stall_i | pixel_class, frame_done, frame_color,
//          |           |                           | red/green/amber_total
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  one pixel per clock sustained while out_stall_i is low
//  pixel register feeds classifier and counters, result register holds the output
//  counters advance when a pixel moves into the result register
//  reset loads threshold defaults and clears counters; config always ready
//  out_stall_i holds the result and backs up into in_stall_o once the pixel register is full
module hsv_signal_light_classifier_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          hue_half_deg_i,
  input  logic [7:0]                          saturation_i,
  input  logic [7:0]                          brightness_i,
  input  logic                                frame_last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          pixel_class_o,
  output logic                                frame_done_o,
  output logic [1:0]                          frame_color_o,
  output logic [hslc_pkg::CountBits-1:0]      red_total_o,
  output logic [hslc_pkg::CountBits-1:0]      green_total_o,
  output logic [hslc_pkg::CountBits-1:0]      amber_total_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hslc_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [7:0]                          cfg_data_i
);
  import hslc_pkg::*;

  thresh_t      thresh_q;
  logic         pix_valid_q;
  logic [7:0]   hue_q;
  logic [7:0]   sat_q;
  logic [7:0]   bright_q;
  logic         last_q;
  logic         res_valid_q;
  pixel_class_e res_class_q;
  logic         res_done_q;
  pixel_class_e res_color_q;
  count_t       res_red_q;
  count_t       res_green_q;
  count_t       res_amber_q;

  logic         res_load;
  logic         pix_advance;
  logic         pix_take;
  pixel_class_e pix_class;
  pixel_class_e win_color;
  count_t       red_tot;
  count_t       green_tot;
  count_t       amber_tot;
  tally_ctrl_t  tally_ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.red_sat_min <= RedSatRst;
      thresh_q.green_sat_min <= GreenSatRst;
      thresh_q.amber_sat_min <= AmberSatRst;
      thresh_q.value_min <= ValueRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RED_SAT:   thresh_q.red_sat_min <= cfg_data_i;
        REG_GREEN_SAT: thresh_q.green_sat_min <= cfg_data_i;
        REG_AMBER_SAT: thresh_q.amber_sat_min <= cfg_data_i;
        REG_VALUE_MIN: thresh_q.value_min <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign res_load = !res_valid_q || !out_stall_i;
  assign pix_advance = pix_valid_q && res_load;
  assign in_stall_o = pix_valid_q && !res_load;
  assign pix_take = in_valid_i && !in_stall_o;

  hslc_classify u_classify (
    .thresh_i       (thresh_q),
    .hue_half_deg_i (hue_q),
    .saturation_i   (sat_q),
    .brightness_i   (bright_q),
    .pixel_class_o  (pix_class)
  );

  assign tally_ctrl.step = pix_advance;
  assign tally_ctrl.last = last_q;
  assign tally_ctrl.cls = pix_class;

  hslc_tally u_tally (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (tally_ctrl),
    .red_total_o   (red_tot),
    .green_total_o (green_tot),
    .amber_total_o (amber_tot),
    .frame_color_o (win_color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (pix_take) begin
        pix_valid_q <= 1'b1;
      end else if (pix_advance) begin
        pix_valid_q <= 1'b0;
      end
      if (res_load) begin
        res_valid_q <= pix_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_take) begin
      hue_q <= hue_half_deg_i;
      sat_q <= saturation_i;
      bright_q <= brightness_i;
      last_q <= frame_last_i;
    end
    if (pix_advance) begin
      res_class_q <= pix_class;
      res_done_q <= last_q;
      res_color_q <= win_color;
      res_red_q <= red_tot;
      res_green_q <= green_tot;
      res_amber_q <= amber_tot;
    end
  end

  assign out_valid_o = res_valid_q;
  assign pixel_class_o = res_class_q;
  assign frame_done_o = res_done_q;
  assign frame_color_o = res_color_q;
  assign red_total_o = res_red_q;
  assign green_total_o = res_green_q;
  assign amber_total_o = res_amber_q;

endmodule

// ===== rtl/core/hslc_checker.sv =====
// port-level assertions for the hsv signal light classifier and its bind
module hslc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [1:0]                      pixel_class_o,
  input logic                            frame_done_o,
  input logic [1:0]                      frame_color_o,
  input logic [hslc_pkg::CountBits-1:0]  red_total_o,
  input logic [hslc_pkg::CountBits-1:0]  green_total_o,
  input logic [hslc_pkg::CountBits-1:0]  amber_total_o
);
  import hslc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_color_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> frame_color_o == CLS_NONE)
    else $error("frame color outside frame end");

  a_red_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_class_o == CLS_RED |-> red_total_o != '0)
    else $error("red pixel not counted");

  a_red_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_color_o == CLS_RED |->
      red_total_o != '0 && red_total_o >= green_total_o && red_total_o >= amber_total_o)
    else $error("red winner without largest count");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

endmodule

bind hsv_signal_light_classifier_core hslc_checker u_hslc_checker (.*);

// ===== verif/hsv_signal_light_classifier_core_test.sv =====
// self-checking testbench for the hsv signal light classifier core
module hsv_signal_light_classifier_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hslc_pkg::*;

  localparam int unsigned WatchdogCycles = 2000;
  localparam int unsigned DrainCycles = 4;

  typedef struct {
    pixel_class_e cls;
    logic         done;
    pixel_class_e color;
    count_t       red;
    count_t       green;
    count_t       amber;
  } light_result_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            hue_half_deg_i = '0;
  logic [7:0]            saturation_i = '0;
  logic [7:0]            brightness_i = '0;
  logic                  frame_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            pixel_class_o;
  logic                  frame_done_o;
  logic [1:0]            frame_color_o;
  logic [CountBits-1:0]  red_total_o;
  logic [CountBits-1:0]  green_total_o;
  logic [CountBits-1:0]  amber_total_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [7:0]            cfg_data_i = '0;

  thresh_t       thr;
  count_t        red_count;
  count_t        green_count;
  count_t        amber_count;
  light_result_t expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  hsv_signal_light_classifier_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .hue_half_deg_i (hue_half_deg_i),
    .saturation_i   (saturation_i),
    .brightness_i   (brightness_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_class_o  (pixel_class_o),
    .frame_done_o   (frame_done_o),
    .frame_color_o  (frame_color_o),
    .red_total_o    (red_total_o),
    .green_total_o  (green_total_o),
    .amber_total_o  (amber_total_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic pixel_class_e classify_pixel(input logic [7:0] hue, input logic [7:0] sat,
                                                  input logic [7:0] bri);
    logic [8:0] hue_deg;
    hue_deg = {hue, 1'b0};
    if (bri < thr.value_min) return CLS_NONE;
    if ((hue_deg <= RedHueLo || hue_deg >= RedHueHi) && sat >= thr.red_sat_min) return CLS_RED;
    if (hue_deg >= GreenHueLo && hue_deg <= GreenHueHi && sat >= thr.green_sat_min) begin
      return CLS_GREEN;
    end
    if (hue_deg >= AmberHueLo && hue_deg <= AmberHueHi && sat >= thr.amber_sat_min) begin
      return CLS_AMBER;
    end
    return CLS_NONE;
  endfunction

  function automatic count_t bump_count(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic light_result_t predict_pixel(input logic [7:0] hue, input logic [7:0] sat,
                                                  input logic [7:0] bri, input logic last);
    light_result_t r;
    r.cls = classify_pixel(hue, sat, bri);
    case (r.cls)
      CLS_RED:   red_count = bump_count(red_count);
      CLS_GREEN: green_count = bump_count(green_count);
      CLS_AMBER: amber_count = bump_count(amber_count);
      default: ;
    endcase
    r.done = last;
    r.color = CLS_NONE;
    if (last && (red_count != '0 || green_count != '0 || amber_count != '0)) begin
      if (red_count >= green_count && red_count >= amber_count) r.color = CLS_RED;
      else if (green_count >= amber_count) r.color = CLS_GREEN;
      else r.color = CLS_AMBER;
    end
    r.red = red_count;
    r.green = green_count;
    r.amber = amber_count;
    if (last) begin
      red_count = '0;
      green_count = '0;
      amber_count = '0;
    end
    return r;
  endfunction

  // pixel side
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat, input logic [7:0] bri,
                            input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    hue_half_deg_i <= hue;
    saturation_i   <= sat;
    brightness_i   <= bri;
    frame_last_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(predict_pixel(hue, sat, bri, last));
    pixels_sent++;
    if (last) frames_sent++;
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic end_stream();
    in_valid_i <= 1'b0;
    drain_results();
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_RED_SAT:   thr.red_sat_min = val;
      REG_GREEN_SAT: thr.green_sat_min = val;
      REG_AMBER_SAT: thr.amber_sat_min = val;
      REG_VALUE_MIN: thr.value_min = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_thresholds(input thresh_t t);
    drain_results();
    write_reg(REG_RED_SAT, t.red_sat_min);
    write_reg(REG_GREEN_SAT, t.green_sat_min);
    write_reg(REG_AMBER_SAT, t.amber_sat_min);
    write_reg(REG_VALUE_MIN, t.value_min);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idle_mode(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin send_idle_pct = 60; rx_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rx_stall_pct = 60; end
      default: begin send_idle_pct = 11; rx_stall_pct = 11; end
    endcase
  endtask

  function automatic logic [7:0] hue_edge();
    case ($urandom_range(12))
      0: return 8'd11;
      1: return 8'd12;
      2: return 8'd14;
      3: return 8'd15;
      4: return 8'd37;
      5: return 8'd38;
      6: return 8'd62;
      7: return 8'd63;
      8: return 8'd103;
      9: return 8'd104;
      10: return 8'd164;
      11: return 8'd165;
      default: return 8'd179;
    endcase
  endfunction

  function automatic logic [7:0] near_threshold(input logic [7:0] t);
    case ($urandom_range(3))
      0: return t - 8'd1;
      1: return t;
      2: return t + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_frame(input int unsigned len);
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bri;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0: hue = hue_edge();
        1: hue = 8'($urandom_range(255, 180));
        default: hue = 8'($urandom_range(179));
      endcase
      case ($urandom_range(2))
        0: sat = near_threshold(thr.red_sat_min);
        1: sat = near_threshold(thr.green_sat_min);
        default: sat = near_threshold(thr.amber_sat_min);
      endcase
      bri = near_threshold(thr.value_min);
      send_pixel(hue, sat, bri, i == len - 1);
    end
  endtask

  task automatic test_directed_edges();
    set_idle_mode(0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd11, 8'd170, 8'd50, 1'b0);
    send_pixel(8'd11, 8'd169, 8'd255, 1'b0);
    send_pixel(8'd12, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd15, 8'd127, 8'd255, 1'b0);
    send_pixel(8'd37, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd38, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd62, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd63, 8'd100, 8'd255, 1'b0);
    send_pixel(8'd103, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd104, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd164, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd165, 8'd170, 8'd255, 1'b0);
    send_pixel(8'd179, 8'd255, 8'd49, 1'b0);
    send_pixel(8'd180, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    // background-only frame gives no winner
    send_pixel(8'd50, 8'd0, 8'd0, 1'b1);
    // green and amber tie
    send_pixel(8'd70, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd20, 8'd255, 8'd255, 1'b1);
    // red and green tie
    send_pixel(8'd5, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd80, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd25, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd90, 8'd255, 8'd255, 1'b1);
    end_stream();
  endtask

  task automatic test_threshold_sweep();
    thresh_t settings[6];
    settings[0] = '{8'd0, 8'd0, 8'd0, 8'd0};
    settings[1] = '{8'd255, 8'd255, 8'd255, 8'd255};
    settings[2] = '{8'd0, 8'd0, 8'd0, 8'd255};
    settings[3] = '{8'd255, 8'd255, 8'd255, 8'd0};
    settings[4] = thresh_t'($urandom);
    settings[5] = '{RedSatRst, GreenSatRst, AmberSatRst, ValueRst};
    set_idle_mode(3);
    foreach (settings[k]) begin
      apply_thresholds(settings[k]);
      send_random_frame($urandom_range(12, 1));
      send_random_frame($urandom_range(12, 1));
      end_stream();
    end
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    int unsigned len;
    for (int unsigned mode = 0; mode < 4; mode++) begin
      set_idle_mode(mode);
      if (mode != 0) apply_thresholds(thresh_t'($urandom));
      sent = 0;
      while (sent < 200) begin
        len = ($urandom_range(7) == 0) ? 1 : $urandom_range(30, 2);
        send_random_frame(len);
        sent += len;
      end
      end_stream();
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < rx_stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    light_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, class %0d", $time, pixel_class_o);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("pixel_class", want.cls, pixel_class_o);
        check_field("frame_done", want.done, frame_done_o);
        check_field("frame_color", want.color, frame_color_o);
        check_field("red_total", want.red, red_total_o);
        check_field("green_total", want.green, green_total_o);
        check_field("amber_total", want.amber, amber_total_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogCycles) begin
      $display("timeout after %0d cycles without a transaction", quiet_cycles);
      $display("FAIL hsv_signal_light_classifier_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    thr = '{RedSatRst, GreenSatRst, AmberSatRst, ValueRst};
    red_count = '0;
    green_count = '0;
    amber_count = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_threshold_sweep();
    test_random_stream();
    drain_results();
    $display("covered %0d pixels in %0d frames with %0d threshold writes",
             pixels_sent, frames_sent, cfg_writes);
    $display("checked %0d results, %0d mismatches, %0d still expected",
             results_checked, mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS hsv_signal_light_classifier_core");
    end else begin
      $display("FAIL hsv_signal_light_classifier_core");
    end
    $finish;
  end

endmodule

// ===== hsv_signal_light_classifier_core.f =====
rtl/core/hslc_pkg.sv
rtl/core/hslc_classify.sv
rtl/core/hslc_tally.sv
rtl/core/hsv_signal_light_classifier_core.sv
rtl/core/hslc_checker.sv
verif/hsv_signal_light_classifier_core_test.sv
